@@ hdl/nqse_pkg.sv @@
// ----------------------------------------------------------------------------
// nqse_pkg
// Shared constants and types for the N-queens solution enumerator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nqse_pkg;

  // width of one stored row number and of the packed placement word
  localparam int unsigned ROW_W  = 4;
  localparam int unsigned PACK_W = 64;

  // width of the board size register and its value after reset
  localparam int unsigned CFG_W       = 5;
  localparam logic [4:0]  BOARD_RESET = 5'd8;

  // status flags that go with one result word
  typedef struct packed {
    logic found;
    logic search_done;
    logic no_solution;
  } res_t;

endpackage

@@ hdl/nqse_ram.sv @@
// ----------------------------------------------------------------------------
// nqse_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nqse_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/n_queens_solution_enumerator.sv @@
// ----------------------------------------------------------------------------
// n_queens_solution_enumerator
// Backtracking N-queens search, one queen per column, rows tried in
// ascending order. Each request word starts a new search or resumes the
// current one; each result word carries the next placement or a done flag.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | in_valid_i  / in_ready_o   | restart_i
//  out     | output    | out_valid_o / out_ready_i  | found_o, rows_packed_o,
//          |           |                            | search_done_o, no_solution_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o  | board_size_i
//
//  Per request: accept, then try rows one at a time, step back when a column
//  runs out of rows; each backtrack step is a step back, then the row stack
//  RAM read; then read the placement out of the row stack and load the
//  result.
//  The work is data dependent; one search sequencer does all placing,
//  rejecting and undoing on one RAM read port.
//  Reset: asynchronous, active low; board size returns to 8, no search active.
//  The row stack needs no clearing pass. A new request is taken once the
//  sequencer is idle, while a previous result may still wait at the output;
//  a stalled output holds the sequencer before it loads the next result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module n_queens_solution_enumerator #(
  parameter int unsigned MAX_BOARD = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        restart_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [nqse_pkg::PACK_W-1:0] rows_packed_o,
  output logic                        search_done_o,
  output logic                        no_solution_o,
  // configuration channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [nqse_pkg::CFG_W-1:0]  board_size_i
);

  localparam int unsigned CW = $clog2(MAX_BOARD + 1);
  localparam int unsigned AW = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
  localparam int unsigned DN = 2 * MAX_BOARD;
  localparam int unsigned SW = $clog2(DN);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TRY   = 3'd1;
  localparam logic [2:0] ST_BACK  = 3'd2;
  localparam logic [2:0] ST_BWAIT = 3'd3;
  localparam logic [2:0] ST_PACK  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]                      state_q, state_d;
  logic [nqse_pkg::CFG_W-1:0]      board_q, board_d;
  logic [CW-1:0]                   col_q, col_d;
  logic [CW-1:0]                   row_q, row_d;
  logic [CW-1:0]                   pk_q, pk_d;
  logic                            rd_vld_q, rd_vld_d;
  logic [AW-1:0]                   rd_col_q, rd_col_d;
  logic [MAX_BOARD-1:0]            rows_taken_q, rows_taken_d;
  logic [DN-1:0]                   dg_dn_q, dg_dn_d;
  logic [DN-1:0]                   dg_up_q, dg_up_d;
  logic                            active_q, active_d;
  logic                            any_found_q, any_found_d;
  logic                            out_valid_q, out_valid_d;
  nqse_pkg::res_t                  res_q, res_d;
  logic [nqse_pkg::PACK_W-1:0]     packed_q, packed_d;
  nqse_pkg::res_t                  out_res_q;
  logic [nqse_pkg::PACK_W-1:0]     out_packed_q;

  logic [CW-1:0]                   n_eff;
  logic [CW-1:0]                   col_m1;
  logic [SW-1:0]                   try_dn_idx, try_up_idx;
  logic [SW-1:0]                   undo_dn_idx, undo_up_idx;
  logic                            busy;
  logic                            out_load;
  logic                            in_fire;
  logic                            cfg_fire;
  logic                            pk_issue;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr, ram_raddr;
  logic [nqse_pkg::ROW_W-1:0]      ram_wdata, ram_rdata;

  // row stack, one entry per column
  nqse_ram #(
    .WIDTH (nqse_pkg::ROW_W),
    .DEPTH (MAX_BOARD)
  ) u_row_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // effective board size: zero acts as one, oversize clamps
  always_comb begin
    if (board_q == '0) begin
      n_eff = CW'(1);
    end else if (board_q > nqse_pkg::CFG_W'(MAX_BOARD)) begin
      n_eff = CW'(MAX_BOARD);
    end else begin
      n_eff = CW'(board_q);
    end
  end

  // handshakes
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i & in_ready_o;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign out_load    = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  // diagonal indices for the row on trial and for the row being undone
  assign col_m1      = col_q - CW'(1);
  assign try_dn_idx  = SW'(col_q) + SW'(MAX_BOARD - 1) - SW'(row_q);
  assign try_up_idx  = SW'(col_q) + SW'(row_q);
  assign undo_dn_idx = SW'(col_q) + SW'(MAX_BOARD - 1) - SW'(ram_rdata);
  assign undo_up_idx = SW'(col_q) + SW'(ram_rdata);
  assign busy        = rows_taken_q[row_q[AW-1:0]] | dg_dn_q[try_dn_idx] |
                       dg_up_q[try_up_idx];
  assign pk_issue    = (pk_q < n_eff);

  // RAM ports: push on placement, pop on backtrack, sweep on readout
  assign ram_we    = (state_q == ST_TRY) && (row_q < n_eff) && !busy;
  assign ram_waddr = col_q[AW-1:0];
  assign ram_wdata = nqse_pkg::ROW_W'(row_q);
  assign ram_raddr = (state_q == ST_PACK) ? pk_q[AW-1:0] : col_m1[AW-1:0];

  // search sequencer
  always_comb begin
    state_d      = state_q;
    board_d      = board_q;
    col_d        = col_q;
    row_d        = row_q;
    pk_d         = pk_q;
    rd_vld_d     = 1'b0;
    rd_col_d     = rd_col_q;
    rows_taken_d = rows_taken_q;
    dg_dn_d      = dg_dn_q;
    dg_up_d      = dg_up_q;
    active_d     = active_q;
    any_found_d  = any_found_q;
    res_d        = res_q;
    packed_d     = packed_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (restart_i) begin
            col_d        = '0;
            row_d        = '0;
            rows_taken_d = '0;
            dg_dn_d      = '0;
            dg_up_d      = '0;
            any_found_d  = 1'b0;
            active_d     = 1'b1;
            state_d      = ST_TRY;
          end else if (active_q) begin
            state_d = ST_BACK;
          end else begin
            res_d    = '{found: 1'b0, search_done: 1'b1, no_solution: !any_found_q};
            packed_d = '0;
            state_d  = ST_EMIT;
          end
        end
      end

      ST_TRY: begin
        if (row_q >= n_eff) begin
          state_d = ST_BACK;
        end else if (busy) begin
          row_d = row_q + CW'(1);
        end else begin
          rows_taken_d[row_q[AW-1:0]] = 1'b1;
          dg_dn_d[try_dn_idx]         = 1'b1;
          dg_up_d[try_up_idx]         = 1'b1;
          col_d                       = col_q + CW'(1);
          row_d                       = '0;
          if ((col_q + CW'(1)) >= n_eff) begin
            pk_d     = '0;
            packed_d = '0;
            state_d  = ST_PACK;
          end
        end
      end

      // step back one column and fetch its row, or report done at column zero
      ST_BACK: begin
        if (col_q == '0) begin
          active_d = 1'b0;
          res_d    = '{found: 1'b0, search_done: 1'b1, no_solution: !any_found_q};
          packed_d = '0;
          state_d  = ST_EMIT;
        end else begin
          col_d   = col_m1;
          state_d = ST_BWAIT;
        end
      end

      // row arrives: lift the queen, resume from the next row
      ST_BWAIT: begin
        rows_taken_d[AW'(ram_rdata)] = 1'b0;
        dg_dn_d[undo_dn_idx]         = 1'b0;
        dg_up_d[undo_up_idx]         = 1'b0;
        row_d                        = CW'(ram_rdata) + CW'(1);
        state_d                      = ST_TRY;
      end

      // read the row stack out into the packed word
      ST_PACK: begin
        if (pk_issue) begin
          rd_vld_d = 1'b1;
          rd_col_d = pk_q[AW-1:0];
          pk_d     = pk_q + CW'(1);
        end
        if (rd_vld_q) begin
          packed_d[rd_col_q * nqse_pkg::ROW_W +: nqse_pkg::ROW_W] = ram_rdata;
        end
        if (!pk_issue && !rd_vld_q) begin
          any_found_d = 1'b1;
          res_d       = '{found: 1'b1, search_done: 1'b0, no_solution: 1'b0};
          state_d     = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a board size write aborts any search
    if (cfg_fire) begin
      board_d      = board_size_i;
      col_d        = '0;
      rows_taken_d = '0;
      dg_dn_d      = '0;
      dg_up_d      = '0;
      active_d     = 1'b0;
      any_found_d  = 1'b0;
    end
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      board_q      <= nqse_pkg::BOARD_RESET;
      col_q        <= '0;
      row_q        <= '0;
      pk_q         <= '0;
      rd_vld_q     <= 1'b0;
      rows_taken_q <= '0;
      dg_dn_q      <= '0;
      dg_up_q      <= '0;
      active_q     <= 1'b0;
      any_found_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      board_q      <= board_d;
      col_q        <= col_d;
      row_q        <= row_d;
      pk_q         <= pk_d;
      rd_vld_q     <= rd_vld_d;
      rows_taken_q <= rows_taken_d;
      dg_dn_q      <= dg_dn_d;
      dg_up_q      <= dg_up_d;
      active_q     <= active_d;
      any_found_q  <= any_found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_col_q <= rd_col_d;
    res_q    <= res_d;
    packed_q <= packed_d;
    if (out_load) begin
      out_res_q    <= res_q;
      out_packed_q <= packed_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_res_q.found;
  assign rows_packed_o = out_packed_q;
  assign search_done_o = out_res_q.search_done;
  assign no_solution_o = out_res_q.no_solution;

  // checks
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= n_eff)
    else $error("column counter beyond board size");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != ST_IDLE))
    else $error("accepted request did not start work");

  a_bwait_after_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BWAIT) |-> ($past(state_q) == ST_BACK))
    else $error("stack pop without a preceding read");

  a_result_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (found_o != search_done_o) && !(found_o && no_solution_o))
    else $error("inconsistent result flags");

  a_empty_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (rows_packed_o == '0))
    else $error("placement word not clear on done result");

endmodule

@@ tb/sv/n_queens_solution_enumerator_tb.sv @@
// ----------------------------------------------------------------------------
// n_queens_solution_enumerator_tb
// Self-checking bench for the N-queens enumerator. A scoreboard class runs
// its own backtracking search alongside the block and queues the expected
// result word for every request taken. Directed words cover idle continues,
// boards with no placement, out-of-range sizes and aborted searches. Random
// phases then walk many board sizes with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// one expected result word
typedef struct packed {
  nqse_pkg::res_t              flags;
  logic [nqse_pkg::PACK_W-1:0] rows;
} placement_t;

class placement_scoreboard;
  localparam int unsigned BOARD_MAX = 16;
  localparam int unsigned DIAG_W    = 2 * BOARD_MAX - 1;
  localparam int unsigned PRINT_CAP = 100;

  // predictor copy of the search state
  bit [nqse_pkg::ROW_W-1:0] row_stack [BOARD_MAX];
  int unsigned              column;
  bit [BOARD_MAX-1:0]       rows_taken;
  bit [DIAG_W-1:0]          diag_down;
  bit [DIAG_W-1:0]          diag_up;
  bit                       active;
  bit                       any_found;
  bit [nqse_pkg::CFG_W-1:0] size_reg = nqse_pkg::BOARD_RESET;

  placement_t               expected_q [$];
  int unsigned              errors;

  // size 0 acts as 1, anything past the maximum as the maximum
  function int unsigned board_rows();
    if (size_reg == 0) return 1;
    if (size_reg > BOARD_MAX) return BOARD_MAX;
    return 32'(size_reg);
  endfunction

  function void clear_board();
    foreach (row_stack[i]) row_stack[i] = '0;
    column     = 0;
    rows_taken = '0;
    diag_down  = '0;
    diag_up    = '0;
  endfunction

  function void mark(int unsigned col, int unsigned row, bit taken);
    rows_taken[row]                 = taken;
    diag_down[col + BOARD_MAX - 1 - row] = taken;
    diag_up[col + row]              = taken;
  endfunction

  // lift the queen of the previous column, next row to try comes back
  function bit step_back(output int unsigned from);
    int unsigned r;
    from = 0;
    if (column == 0) return 1'b0;
    column--;
    r = 32'(row_stack[column]);
    mark(column, r, 1'b0);
    from = r + 1;
    return 1'b1;
  endfunction

  // place column by column from the current point until full or exhausted
  function bit search(int unsigned from);
    int unsigned n;
    int unsigned col;
    int unsigned r;
    bit          placed;
    n = board_rows();
    while (1'b1) begin
      col    = column;
      placed = 1'b0;
      r      = from;
      while (!placed && r < n) begin
        if (!rows_taken[r] && !diag_down[col + BOARD_MAX - 1 - r] && !diag_up[col + r]) begin
          mark(col, r, 1'b1);
          row_stack[col] = r[nqse_pkg::ROW_W-1:0];
          column         = col + 1;
          placed         = 1'b1;
        end else begin
          r++;
        end
      end
      if (placed) begin
        if (column >= n) return 1'b1;
        from = 0;
      end else if (!step_back(from)) begin
        return 1'b0;
      end
    end
    return 1'b0;
  endfunction

  // a board size write aborts whatever search is running
  function void set_size(bit [nqse_pkg::CFG_W-1:0] value);
    size_reg  = value;
    clear_board();
    active    = 1'b0;
    any_found = 1'b0;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  // work out the word caused by one accepted request
  function void note_request(bit restart);
    placement_t  want;
    int unsigned from;
    bit          ok;
    ok = 1'b0;
    if (restart) begin
      clear_board();
      any_found = 1'b0;
      active    = 1'b1;
      ok        = search(0);
    end else if (active) begin
      ok = step_back(from);
      if (ok) ok = search(from);
    end
    want.rows = '0;
    if (ok) begin
      for (int unsigned c = 0; c < board_rows(); c++) begin
        want.rows[nqse_pkg::ROW_W*c +: nqse_pkg::ROW_W] = row_stack[c];
      end
      any_found              = 1'b1;
      want.flags.found       = 1'b1;
      want.flags.search_done = 1'b0;
      want.flags.no_solution = 1'b0;
    end else begin
      active                 = 1'b0;
      want.flags.found       = 1'b0;
      want.flags.search_done = 1'b1;
      want.flags.no_solution = !any_found;
    end
    expected_q = {expected_q, want};
  endfunction

  task report(string what, logic [nqse_pkg::PACK_W-1:0] got,
              logic [nqse_pkg::PACK_W-1:0] want);
    if (errors < PRINT_CAP) begin
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    end
    errors++;
  endtask

  // compare one accepted result word with the oldest expectation
  task check_result(logic found, logic [nqse_pkg::PACK_W-1:0] rows, logic done,
                    logic nosol);
    placement_t want;
    if (expected_q.size() == 0) begin
      report("unexpected result word", rows, '0);
      return;
    end
    want = expected_q.pop_front();
    if (found !== want.flags.found)
      report("found", nqse_pkg::PACK_W'(found), nqse_pkg::PACK_W'(want.flags.found));
    if (rows !== want.rows) report("rows_packed", rows, want.rows);
    if (done !== want.flags.search_done)
      report("search_done", nqse_pkg::PACK_W'(done),
             nqse_pkg::PACK_W'(want.flags.search_done));
    if (nosol !== want.flags.no_solution)
      report("no_solution", nqse_pkg::PACK_W'(nosol),
             nqse_pkg::PACK_W'(want.flags.no_solution));
  endtask
endclass

module n_queens_solution_enumerator_tb;

  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned MAX_GAP       = 5;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned HOLD_CYCLES   = 2000;
  localparam int unsigned RANDOM_ITEMS  = 1500;
  // sized so that the first placement on a 16x16 board is not taken for a stall
  localparam int unsigned STALL_LIMIT   = 2000000;

  localparam bit NEW_SEARCH    = 1'b1;
  localparam bit NEXT_SOLUTION = 1'b0;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        in_valid_i    = 1'b0;
  logic                        in_ready_o;
  logic                        restart_i     = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i   = 1'b0;
  logic                        found_o;
  logic [nqse_pkg::PACK_W-1:0] rows_packed_o;
  logic                        search_done_o;
  logic                        no_solution_o;
  logic                        cfg_valid_i   = 1'b0;
  logic                        cfg_ready_o;
  logic [nqse_pkg::CFG_W-1:0]  board_size_i  = nqse_pkg::BOARD_RESET;

  placement_scoreboard sb = new();

  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  bit hold_req   = 1'b0;

  n_queens_solution_enumerator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .rows_packed_o (rows_packed_o),
    .search_done_o (search_done_o),
    .no_solution_o (no_solution_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .board_size_i  (board_size_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // offer one request word after a random gap, return once it is taken
  task automatic send_request(input bit restart);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    sb.note_request(restart);
  endtask

  // stop offering and wait for every outstanding result word
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_board_size(input logic [nqse_pkg::CFG_W-1:0] value);
    cfg_valid_i  <= 1'b1;
    board_size_i <= value;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    sb.set_size(value);
  endtask

  // result side: random gaps, bursts with none, and one long hold-off on request
  initial begin
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
      gap = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      sb.check_result(found_o, rows_packed_o, search_done_o, no_solution_o);
    end
  end

  // watchdog: ends the run when no word moves on any channel for too long
  initial begin
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("%0t watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("[n_queens_solution_enumerator] ERROR");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned                random_items;
    int unsigned                phase_len;
    int unsigned                pick;
    logic [nqse_pkg::CFG_W-1:0] size_val;
    bit                         restart;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // continue before any search has started, reset board size
    send_request(NEXT_SOLUTION);
    send_request(NEW_SEARCH);
    send_request(NEXT_SOLUTION);

    // single square: one placement, then done, and done again while idle
    drain_results();
    write_board_size(5'd1);
    send_request(NEW_SEARCH);
    send_request(NEXT_SOLUTION);
    send_request(NEXT_SOLUTION);

    // size zero behaves as one
    drain_results();
    write_board_size(5'd0);
    send_request(NEW_SEARCH);
    send_request(NEXT_SOLUTION);

    // boards with no placement at all
    drain_results();
    write_board_size(5'd2);
    send_request(NEW_SEARCH);
    send_request(NEXT_SOLUTION);
    drain_results();
    write_board_size(5'd3);
    send_request(NEW_SEARCH);

    // two placements, exhaustion, then restarts in and out of a search
    drain_results();
    write_board_size(5'd4);
    send_request(NEW_SEARCH);
    send_request(NEXT_SOLUTION);
    send_request(NEXT_SOLUTION);
    send_request(NEW_SEARCH);
    send_request(NEW_SEARCH);

    // largest board, then an oversized value that clamps to it
    drain_results();
    write_board_size(5'd16);
    send_request(NEW_SEARCH);
    send_request(NEXT_SOLUTION);
    drain_results();
    write_board_size(5'd31);
    send_request(NEW_SEARCH);

    // the write drops the running search, so a continue finds nothing
    drain_results();
    write_board_size(5'd5);
    send_request(NEXT_SOLUTION);

    // random phases: mostly a restart followed by continues
    random_items = 0;
    hold_req     = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) size_val = 5'd0;
      else if (pick <= 12) size_val = nqse_pkg::CFG_W'($urandom_range(1, 9));
      else if (pick <= 14) size_val = nqse_pkg::CFG_W'($urandom_range(10, 12));
      else size_val = nqse_pkg::CFG_W'($urandom_range(13, 14));
      drain_results();
      write_board_size(size_val);
      phase_len = (size_val <= 8) ? $urandom_range(40, 110) : $urandom_range(10, 40);
      if ($urandom_range(0, 31) == 0) hold_req = 1'b1;
      for (int unsigned k = 0; k < phase_len; k++) begin
        if (k == 0) restart = ($urandom_range(0, 7) != 0);
        else restart = ($urandom_range(0, 11) == 0);
        send_request(restart);
        if ($urandom_range(0, 63) == 0) drain_results();
      end
      random_items += phase_len;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[n_queens_solution_enumerator] OK");
    end else begin
      $display("[n_queens_solution_enumerator] ERROR");
    end
    $finish;
  end

endmodule
